FILE: design/http_request_tokenizer_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef HTTP_REQUEST_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_TOKENIZER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define HRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define HRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/hrt_pkg.sv
// Shared types and constants of the HTTP request tokenizer.
package hrt_pkg;

    localparam int DEF_BUFFER_BYTES = 4096;
    localparam int DEF_MAX_HEADERS  = 32;
    localparam int POS_CAP          = 4096;
    localparam int QUEUE_DEPTH      = 4;

    localparam int OFF_W   = 12;
    localparam int HDR_W   = 5;
    localparam int KIND_W  = 3;
    localparam int ERR_W   = 3;
    localparam int LIMIT_W = 6;
    localparam int SEEN_W  = 6;

    localparam logic [LIMIT_W-1:0] HEADER_LIMIT_RESET = 6'd32;
    localparam logic               REG_HEADER_LIMIT   = 1'b0;

    localparam logic [KIND_W-1:0] KIND_METHOD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PATH    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VERSION = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NAME    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VALUE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd6;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_LINE = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NO_COLON = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TOO_MANY = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRUNC    = 3'd4;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFF_W-1:0]  offset;
        logic [OFF_W-1:0]  length;
        logic [HDR_W-1:0]  header_number;
        logic [ERR_W-1:0]  error_code;
    } t_result;

endpackage

FILE: design/hrt_front.sv
// Byte classifier: request and header state machine that emits token records.
module hrt_front #(
    parameter int BUFFER_BYTES = hrt_pkg::DEF_BUFFER_BYTES,
    parameter int MAX_HEADERS  = hrt_pkg::DEF_MAX_HEADERS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_frame_start,
    input  logic                         i_end_of_buffer,
    input  logic [hrt_pkg::LIMIT_W-1:0]  i_header_limit,
    input  logic                         i_full,
    output logic                         o_stall,
    output logic                         o_push,
    output hrt_pkg::t_result             o_result
);
    import hrt_pkg::*;

    localparam int POS_LIMIT = (BUFFER_BYTES > POS_CAP) ? POS_CAP : BUFFER_BYTES;
    localparam int PW        = $clog2(POS_LIMIT + 1);
    localparam int WW        = (PW > OFF_W) ? PW : OFF_W;
    localparam int LW        = $clog2(MAX_HEADERS + 1) + 1;

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_METHOD     = 4'd1;
    localparam logic [3:0] PH_PATH       = 4'd2;
    localparam logic [3:0] PH_VERSION    = 4'd3;
    localparam logic [3:0] PH_VERSION_CR = 4'd4;
    localparam logic [3:0] PH_LINE_START = 4'd5;
    localparam logic [3:0] PH_BLANK_CR   = 4'd6;
    localparam logic [3:0] PH_NAME       = 4'd7;
    localparam logic [3:0] PH_VALUE_SKIP = 4'd8;
    localparam logic [3:0] PH_VALUE      = 4'd9;
    localparam logic [3:0] PH_VALUE_CR   = 4'd10;
    localparam logic [3:0] PH_DONE       = 4'd11;

    logic [3:0]        r_phase, n_phase;
    logic [PW-1:0]     r_pos,   n_pos;
    logic [PW-1:0]     r_begin, n_begin;
    logic [SEEN_W-1:0] r_seen,  n_seen;

    logic              w_accept;
    logic [3:0]        w_phase;
    logic [PW-1:0]     w_pos, w_begin;
    logic [SEEN_W-1:0] w_seen;
    logic [WW-1:0]     w_pos_w, w_begin_w, w_len_sp, w_len_crlf, w_body;
    logic [LW-1:0]     w_lim;
    logic              w_at_limit;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;

    assign w_phase = i_frame_start ? PH_METHOD : r_phase;
    assign w_pos   = i_frame_start ? '0 : r_pos;
    assign w_begin = i_frame_start ? '0 : r_begin;
    assign w_seen  = i_frame_start ? '0 : r_seen;

    assign w_pos_w    = WW'(w_pos);
    assign w_begin_w  = WW'(w_begin);
    assign w_len_sp   = w_pos_w - w_begin_w;
    assign w_len_crlf = w_pos_w - WW'(1) - w_begin_w;
    assign w_body     = w_pos_w + WW'(1);

    // Effective header limit: zero acts as one, capped at the build maximum.
    always_comb begin
        w_lim = (i_header_limit == '0) ? LW'(1) : LW'(i_header_limit);
        if (w_lim > LW'(MAX_HEADERS)) begin
            w_lim = LW'(MAX_HEADERS);
        end
    end
    assign w_at_limit = LW'(w_seen) >= w_lim;

    always_comb begin
        logic             emit;
        logic             step;
        logic [ERR_W-1:0] err;
        t_result          res;

        emit    = 1'b0;
        step    = 1'b1;
        err     = ERR_NONE;
        res     = '0;
        n_phase = w_phase;
        n_pos   = w_pos;
        n_begin = w_begin;
        n_seen  = w_seen;

        if (w_phase == PH_IDLE || w_phase == PH_DONE) begin
            step = 1'b0;
        end else if (w_pos >= PW'(POS_LIMIT)) begin
            step = 1'b0;
            err  = ERR_TRUNC;
        end else begin
            case (w_phase)
                PH_METHOD, PH_PATH: begin
                    if (i_data_byte == CH_SP) begin
                        emit       = 1'b1;
                        res.kind   = (w_phase == PH_METHOD) ? KIND_METHOD : KIND_PATH;
                        res.offset = OFF_W'(w_begin_w);
                        res.length = w_len_sp[OFF_W-1:0];
                        n_phase    = (w_phase == PH_METHOD) ? PH_PATH : PH_VERSION;
                        n_begin    = w_pos + PW'(1);
                    end else if (i_data_byte == CH_CR || i_data_byte == CH_LF) begin
                        err = ERR_BAD_LINE;
                    end
                end
                PH_VERSION: begin
                    if (i_data_byte == CH_CR) begin
                        n_phase = PH_VERSION_CR;
                    end
                end
                PH_VERSION_CR: begin
                    if (i_data_byte == CH_LF) begin
                        emit       = 1'b1;
                        res.kind   = KIND_VERSION;
                        res.offset = OFF_W'(w_begin_w);
                        res.length = w_len_crlf[OFF_W-1:0];
                        n_phase    = PH_LINE_START;
                        n_begin    = w_pos + PW'(1);
                    end else if (i_data_byte != CH_CR) begin
                        n_phase = PH_VERSION;
                    end
                end
                PH_LINE_START: begin
                    if (i_data_byte == CH_CR) begin
                        n_phase = PH_BLANK_CR;
                    end else if (i_data_byte == CH_LF) begin
                        err = ERR_NO_COLON;
                    end else if (w_at_limit) begin
                        err = ERR_TOO_MANY;
                    end else if (i_data_byte == CH_COLON) begin
                        emit              = 1'b1;
                        res.kind          = KIND_NAME;
                        res.offset        = OFF_W'(w_begin_w);
                        res.header_number = w_seen[HDR_W-1:0];
                        n_phase           = PH_VALUE_SKIP;
                    end else begin
                        n_phase = PH_NAME;
                    end
                end
                PH_BLANK_CR: begin
                    if (i_data_byte == CH_LF) begin
                        emit              = 1'b1;
                        res.kind          = KIND_END;
                        res.offset        = w_body[OFF_W-1:0];
                        res.header_number = w_seen[HDR_W-1:0];
                        n_phase           = PH_DONE;
                    end else begin
                        err = ERR_NO_COLON;
                    end
                end
                PH_NAME: begin
                    if (i_data_byte == CH_COLON) begin
                        emit              = 1'b1;
                        res.kind          = KIND_NAME;
                        res.offset        = OFF_W'(w_begin_w);
                        res.length        = w_len_sp[OFF_W-1:0];
                        res.header_number = w_seen[HDR_W-1:0];
                        n_phase           = PH_VALUE_SKIP;
                    end else if (i_data_byte == CH_CR || i_data_byte == CH_LF) begin
                        err = ERR_NO_COLON;
                    end
                end
                PH_VALUE_SKIP: begin
                    if (i_data_byte != CH_SP) begin
                        n_begin = w_pos;
                        n_phase = (i_data_byte == CH_CR) ? PH_VALUE_CR : PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (i_data_byte == CH_CR) begin
                        n_phase = PH_VALUE_CR;
                    end
                end
                PH_VALUE_CR: begin
                    if (i_data_byte == CH_LF) begin
                        emit              = 1'b1;
                        res.kind          = KIND_VALUE;
                        res.offset        = OFF_W'(w_begin_w);
                        res.length        = w_len_crlf[OFF_W-1:0];
                        res.header_number = w_seen[HDR_W-1:0];
                        if (w_seen != '1) begin
                            n_seen = w_seen + SEEN_W'(1);
                        end
                        n_phase = PH_LINE_START;
                        n_begin = w_pos + PW'(1);
                    end else if (i_data_byte != CH_CR) begin
                        n_phase = PH_VALUE;
                    end
                end
                default: begin
                    // Unused phase codes: drop back to idle silently.
                    n_phase = PH_IDLE;
                    step    = 1'b0;
                end
            endcase
            if (step) begin
                n_pos = w_pos + PW'(1);
            end
        end

        // Last byte that does not finish the headers truncates the request.
        if (step && err == ERR_NONE && i_end_of_buffer && n_phase != PH_DONE) begin
            err = ERR_TRUNC;
        end
        if (err != ERR_NONE) begin
            emit              = 1'b1;
            res               = '0;
            res.kind          = KIND_ERROR;
            res.offset        = OFF_W'(w_pos_w);
            res.header_number = n_seen[HDR_W-1:0];
            res.error_code    = err;
            n_phase           = PH_IDLE;
        end

        o_push   = w_accept && emit;
        o_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_seen  <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_seen  <= n_seen;
        end
    end

endmodule

FILE: design/hrt_queue.sv
// Small FIFO of token records between the classifier and the output stage.
module hrt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hrt_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output hrt_pkg::t_result o_data
);
    import hrt_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_result         r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == CW'(QUEUE_DEPTH);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: design/hrt_back.sv
// Output stage: registers one token record and presents it to the consumer.
module hrt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  hrt_pkg::t_result i_q_data,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output hrt_pkg::t_result o_data
);
    import hrt_pkg::*;

    logic    r_valid;
    t_result r_data;
    logic    w_load;

    // Refill whenever the held beat is gone or about to be taken.
    assign w_load  = !r_valid || !i_stall;
    assign o_pop   = w_load && i_q_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_data;
        end
    end

endmodule

FILE: design/http_request_tokenizer.sv
// HTTP request tokenizer top level: byte classifier, record queue, output register.
// Throughput: one byte beat per cycle; the classifier stalls only when the queue is full.
// Path: a token record leaves through the queue, then the output register, and is held
// there while the consumer stalls.
// Reset (synchronous, active low): parser idle until a frame start, queue and output empty,
// header_limit back to 32.
`include "http_request_tokenizer_macros.svh"

module http_request_tokenizer #(
    parameter int BUFFER_BYTES = hrt_pkg::DEF_BUFFER_BYTES,
    parameter int MAX_HEADERS  = hrt_pkg::DEF_MAX_HEADERS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input byte channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_frame_start,
    input  logic                        i_end_of_buffer,
    // token channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hrt_pkg::KIND_W-1:0]  o_token_kind,
    output logic [hrt_pkg::OFF_W-1:0]   o_token_offset,
    output logic [hrt_pkg::OFF_W-1:0]   o_token_length,
    output logic [hrt_pkg::HDR_W-1:0]   o_header_number,
    output logic [hrt_pkg::ERR_W-1:0]   o_error_code,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import hrt_pkg::*;

    logic [LIMIT_W-1:0] r_header_limit;
    logic               w_cfg_wr;

    logic    w_push, w_full, w_q_valid, w_pop;
    t_result w_push_data, w_q_data, w_out_data;

    // Configuration: header_limit is the only register, at byte address zero.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HEADER_LIMIT);
    assign prdata   = (paddr[2] == REG_HEADER_LIMIT) ? 32'(r_header_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_limit <= HEADER_LIMIT_RESET;
        end else if (w_cfg_wr) begin
            r_header_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // Front: classify each accepted byte, push a record when a token closes.
    hrt_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_HEADERS  (MAX_HEADERS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_frame_start   (i_frame_start),
        .i_end_of_buffer (i_end_of_buffer),
        .i_header_limit  (r_header_limit),
        .i_full          (w_full),
        .o_stall         (o_stall),
        .o_push          (w_push),
        .o_result        (w_push_data)
    );

    // Queue: absorb records while the consumer holds off.
    hrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_data  (w_q_data)
    );

    // Back: hold one record in the output register until its beat is taken.
    hrt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_data    (w_out_data)
    );

    assign o_token_kind    = w_out_data.kind;
    assign o_token_offset  = w_out_data.offset;
    assign o_token_length  = w_out_data.length;
    assign o_header_number = w_out_data.header_number;
    assign o_error_code    = w_out_data.error_code;

    // A record is pushed only while the queue has room.
    `HRT_ASSERT_NOW(a_push_room, i_clk, i_rst_n, w_push, !w_full, "push into full queue")
    // Error beats and only error beats carry an error code.
    `HRT_ASSERT_NOW(a_err_code, i_clk, i_rst_n, o_valid,
        ((o_token_kind == KIND_ERROR) == (o_error_code != ERR_NONE)), "error code mismatch")
    // Headers end and error beats report zero length.
    `HRT_ASSERT_NOW(a_zero_len, i_clk, i_rst_n,
        o_valid && (o_token_kind == KIND_END || o_token_kind == KIND_ERROR),
        o_token_length == '0, "nonzero length on end or error")
    // A beat popped from the queue shows on the output next cycle.
    `HRT_ASSERT_NEXT(a_pop_show, i_clk, i_rst_n, w_pop, o_valid, "popped record not shown")

endmodule
